// ===== design/lpml_pkg.sv =====
// Types and constants shared by the longest-prefix-match lookup unit.
`timescale 1ns / 1ps

package lpml_pkg;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [3:0]  slot;
      logic        slot_valid;
      logic [31:0] route_prefix_in;
      logic [31:0] route_mask_in;
      logic [31:0] route_gateway_in;
      logic [1:0]  route_port_in;
      logic [31:0] lookup_address;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  matched_slot;
      logic [1:0]  out_port;
      logic [31:0] next_hop;
      logic [31:0] matched_mask;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [1:0]  port;
   } route_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// ===== design/lpml_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module lpml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/longest_prefix_match_lookup_unit.sv =====
// Top level of the IPv4 longest-prefix-match route table.
`timescale 1ns / 1ps

// Usage
//   Input: drive req_word and raise start; the word is taken at a rising edge
//   where start is high and busy is low.
//   mode = write: the slot is installed (slot_valid = 1) or cleared at that
//   edge. A write to a slot at or beyond TABLE_DEPTH changes nothing. The
//   all-zero response strobes in the next cycle; busy stays low, so writes
//   can go back to back.
//   mode = lookup: the table is scanned one slot per clock from the route
//   RAM (one read port, registered read data), then the DONE state selects
//   the result and registers it. busy is high from the accept edge until
//   rsp_strobe rises, so no new word is taken while a lookup is in flight.
//   The scan always covers all TABLE_DEPTH slots.
//   Winner: greatest mask among matching slots, lowest slot on a tie.
//   next_hop is the gateway, or the looked-up address when the gateway is 0.
//   Output: each response is on rsp_word with rsp_strobe high for exactly
//   one cycle; the receiver cannot stall it.
//   Reset: synchronous, active high; all slots become empty, nothing is
//   in flight. Route words in RAM are not cleared, only the used bits.
module longest_prefix_match_lookup_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lpml_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output lpml_pkg::rsp_word_type rsp_word
);

   localparam int AW = $clog2((TABLE_DEPTH > 1) ? TABLE_DEPTH : 2);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
   localparam int EW = $bits(lpml_pkg::route_entry_type);

   lpml_pkg::state_type state_ff, state_in;

   // scan position: RAM output in SCAN belongs to cur_ff
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] rd_addr;

   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic                   used_q_ff;

   logic [31:0]                addr_ff, addr_in;
   logic                       found_ff, found_in;
   logic [AW-1:0]              best_idx_ff, best_idx_in;
   lpml_pkg::route_entry_type  best_ff, best_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   lpml_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                      accept;
   logic                      slot_in_range;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   lpml_pkg::route_entry_type ram_wr_data;
   logic [EW-1:0]             ram_rd_bits;
   lpml_pkg::route_entry_type rd_entry;
   logic                      slot_match;
   logic                      slot_better;

   assign busy   = (state_ff != lpml_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign slot_in_range = (32'(req_word.slot) < TABLE_DEPTH);
   assign ram_wr_addr   = AW'(req_word.slot);
   assign ram_wr_en     = accept && (req_word.mode == lpml_pkg::MODE_WRITE)
                          && slot_in_range && req_word.slot_valid;

   always_comb begin
      ram_wr_data.prefix  = req_word.route_prefix_in;
      ram_wr_data.mask    = req_word.route_mask_in;
      ram_wr_data.gateway = req_word.route_gateway_in;
      ram_wr_data.port    = req_word.route_port_in;
   end

   // In IDLE slot 0 is read ahead, so its data is there in the first SCAN cycle.
   always_comb begin
      if (state_ff == lpml_pkg::ST_SCAN && cur_ff != LAST_SLOT) begin
         rd_addr = cur_ff + AW'(1);
      end else begin
         rd_addr = '0;
      end
   end

   lpml_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign rd_entry = lpml_pkg::route_entry_type'(ram_rd_bits);

   // match test and priority: a strictly greater mask replaces the holder,
   // so ties keep the lower slot
   assign slot_match  = used_q_ff
                        && ((addr_ff & rd_entry.mask) == (rd_entry.prefix & rd_entry.mask));
   assign slot_better = slot_match && (!found_ff || (rd_entry.mask > best_ff.mask));

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      addr_in       = addr_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      unique case (state_ff)
         lpml_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_word.mode == lpml_pkg::MODE_WRITE) begin
                  if (slot_in_range) begin
                     used_in[ram_wr_addr] = req_word.slot_valid;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_word_in   = '0;
               end else begin
                  addr_in  = req_word.lookup_address;
                  found_in = 1'b0;
                  cur_in   = '0;
                  state_in = lpml_pkg::ST_SCAN;
               end
            end
         end
         lpml_pkg::ST_SCAN: begin
            if (slot_better) begin
               found_in    = 1'b1;
               best_idx_in = cur_ff;
               best_in     = rd_entry;
            end
            if (cur_ff == LAST_SLOT) begin
               state_in = lpml_pkg::ST_DONE;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end
         lpml_pkg::ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '0;
            if (found_ff) begin
               rsp_word_in.hit          = 1'b1;
               rsp_word_in.matched_slot = 4'(best_idx_ff);
               rsp_word_in.out_port     = best_ff.port;
               rsp_word_in.next_hop     = (best_ff.gateway != 32'd0) ? best_ff.gateway
                                                                     : addr_ff;
               rsp_word_in.matched_mask = best_ff.mask;
            end
            state_in = lpml_pkg::ST_IDLE;
         end
         default: begin
            state_in = lpml_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpml_pkg::ST_IDLE;
         used_ff       <= '0;
         found_ff      <= 1'b0;
         cur_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         found_ff      <= found_in;
         cur_ff        <= cur_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      used_q_ff   <= used_ff[rd_addr];
      addr_ff     <= addr_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
